// ===== src/svf_pkg.sv =====
package svf_pkg;

  localparam int SVF_QUEUE_DEPTH = 2;
  localparam logic [15:0] SVF_POLY_RESET = 16'h1021;
  localparam logic [7:0] SVF_SYNC = 8'hA5;

  typedef enum logic [3:0] {
    OP_WR_SPEED    = 4'd0,
    OP_WR_CURRENT  = 4'd1,
    OP_WR_POSITION = 4'd2,
    OP_RD_CURRENT  = 4'd3,
    OP_RD_SPEED    = 4'd4,
    OP_RD_POSITION = 4'd5,
    OP_ACCESS      = 4'd6,
    OP_ENABLE      = 4'd7,
    OP_DISABLE     = 4'd8
  } op_t;

  localparam logic [7:0] CTRL_RD = 8'h01;
  localparam logic [7:0] CTRL_WR = 8'h02;
  localparam logic [7:0] CODE_WRITE = 8'h45;
  localparam logic [7:0] CODE_RD_CURRENT = 8'h10;
  localparam logic [7:0] CODE_RD_SPEED = 8'h11;
  localparam logic [7:0] CODE_RD_POSITION = 8'h12;
  localparam logic [7:0] CODE_ACCESS = 8'h07;
  localparam logic [7:0] CODE_BRIDGE = 8'h01;
  localparam logic [7:0] ACCESS_KEY = 8'h0F;

  // Payload length in bytes: none, two or four.
  typedef enum logic [2:0] {
    PL_NONE = 3'd0,
    PL_TWO  = 3'd2,
    PL_FOUR = 3'd4
  } pl_t;

  localparam logic [3:0] POS_HDR_CRC_HI = 4'd6;
  localparam logic [3:0] POS_HDR_CRC_LO = 4'd7;
  localparam logic [3:0] POS_PAYLOAD = 4'd8;

  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  ctrl;
    logic [7:0]  code;
    logic [7:0]  fidx;
    logic [7:0]  words;
    logic [31:0] payload;
    pl_t         paylen;
  } desc_t;

  // Direct-form CRC-16 over one byte, MSB first. With zero init this gives
  // the same value as the augmented form followed by two zero bytes.
  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in,
                                           input logic [7:0] data,
                                           input logic [15:0] poly);
    logic [15:0] acc;
    logic        top;
    acc = acc_in;
    for (int k = 7; k >= 0; k--) begin
      top = acc[15] ^ data[k];
      acc = {acc[14:0], 1'b0};
      if (top) begin
        acc = acc ^ poly;
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/svf_if.sv =====
interface svf_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic [7:0]         address;
  logic [7:0]         index;
  logic signed [31:0] value;

  modport source(output valid, output operation, output address, output index,
                 output value, input ready);
  modport sink(input valid, input operation, input address, input index,
               input value, output ready);
endinterface

interface svf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source(output valid, output frame_byte, output last_byte, input ready);
  modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/svf_front.sv =====
module svf_front
  import svf_pkg::*;
(
  svf_req_if.sink in_req,
  input  logic    q_full,
  output logic    push,
  output desc_t   push_desc
);

  logic known;

  assign in_req.ready = !q_full;

  always_comb begin
    known = 1'b1;
    push_desc.addr = in_req.address;
    push_desc.ctrl = CTRL_WR;
    push_desc.code = CODE_BRIDGE;
    push_desc.fidx = 8'h00;
    push_desc.words = 8'h01;
    push_desc.payload = 32'h0;
    push_desc.paylen = PL_TWO;
    unique case (op_t'(in_req.operation))
      OP_WR_SPEED, OP_WR_CURRENT, OP_WR_POSITION: begin
        push_desc.code = CODE_WRITE;
        push_desc.fidx = in_req.index;
        push_desc.words = 8'h02;
        push_desc.payload = in_req.value;
        push_desc.paylen = PL_FOUR;
      end
      OP_RD_CURRENT: begin
        push_desc.ctrl = CTRL_RD;
        push_desc.code = CODE_RD_CURRENT;
        push_desc.fidx = 8'h03;
        push_desc.paylen = PL_NONE;
      end
      OP_RD_SPEED: begin
        push_desc.ctrl = CTRL_RD;
        push_desc.code = CODE_RD_SPEED;
        push_desc.fidx = 8'h02;
        push_desc.words = 8'h02;
        push_desc.paylen = PL_NONE;
      end
      OP_RD_POSITION: begin
        push_desc.ctrl = CTRL_RD;
        push_desc.code = CODE_RD_POSITION;
        push_desc.words = 8'h02;
        push_desc.paylen = PL_NONE;
      end
      OP_ACCESS: begin
        push_desc.code = CODE_ACCESS;
        push_desc.payload = {24'h0, ACCESS_KEY};
      end
      OP_ENABLE: begin
        push_desc.payload = 32'h0;
      end
      OP_DISABLE: begin
        push_desc.payload = 32'h1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown operations are taken and dropped without a frame.
  assign push = in_req.valid && !q_full && known;

endmodule

// ===== src/svf_queue.sv =====
module svf_queue
  import svf_pkg::*;
#(
  parameter int DEPTH = SVF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head_desc,
  output logic  full,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head_desc = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ===== src/svf_back.sv =====
module svf_back
  import svf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] poly,
  input  desc_t       head_desc,
  input  logic        empty,
  output logic        pop,
  svf_byte_if.source  out_byte
);

  logic [3:0]  pos_r, pos_nxt;
  logic [15:0] crc_r;
  logic [7:0]  crc_lo_r;
  logic [15:0] crc_cur;
  logic [3:0]  pos_crc_hi, pos_last;
  logic        at_crc_hi, at_crc_lo, is_last, take;
  logic [7:0]  byte_val;

  // The running CRC covers every byte emitted so far in this frame.
  assign crc_cur = (pos_r == '0) ? 16'h0 : crc_r;
  assign pos_crc_hi = POS_PAYLOAD + {1'b0, head_desc.paylen};
  assign pos_last = (head_desc.paylen == PL_NONE) ? POS_HDR_CRC_LO : pos_crc_hi + 4'd1;
  assign at_crc_hi = (pos_r == POS_HDR_CRC_HI) ||
                     ((head_desc.paylen != PL_NONE) && (pos_r == pos_crc_hi));
  assign at_crc_lo = (pos_r == POS_HDR_CRC_LO) || (pos_r == pos_last);
  assign is_last = (pos_r == pos_last);

  always_comb begin
    case (pos_r)
      4'd0: byte_val = SVF_SYNC;
      4'd1: byte_val = head_desc.addr;
      4'd2: byte_val = head_desc.ctrl;
      4'd3: byte_val = head_desc.code;
      4'd4: byte_val = head_desc.fidx;
      4'd5: byte_val = head_desc.words;
      default: begin
        if (at_crc_hi) begin
          byte_val = crc_cur[15:8];
        end else if (at_crc_lo) begin
          byte_val = crc_lo_r;
        end else begin
          byte_val = head_desc.payload[8*pos_r[1:0] +: 8];
        end
      end
    endcase
  end

  assign out_byte.valid = !empty;
  assign out_byte.frame_byte = byte_val;
  assign out_byte.last_byte = is_last;
  assign take = out_byte.valid && out_byte.ready;
  assign pop = take && is_last;

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = is_last ? '0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc_r <= crc_byte(crc_cur, byte_val, poly);
      if (at_crc_hi) begin
        crc_lo_r <= crc_cur[7:0];
      end
    end
  end

endmodule

// ===== src/servo_drive_command_framer_top.sv =====
// Servo drive command framer.
// in_req takes one drive command request (operation, address, index, value);
// out_byte delivers the serial frame one byte per item, with last_byte set on
// the final byte. Frames are 8 bytes for reads, 12 for access/enable/disable
// and 14 for writes, each with a header CRC and, when a payload follows, a
// second CRC over everything before it. Unknown operations are taken and
// produce no frame.
// The first byte of a frame is offered once its request has been written into
// the queue and any frames ahead of it have gone out; after that one byte
// leaves per cycle while out_byte.ready is high. A small request queue sits
// between the classifier and the emitter, so new requests are taken while a
// frame is still going out.
// When the receiver stalls, the offered byte holds and the queue fills; then
// in_req.ready drops. Reset empties the queue, restarts the byte counter and
// loads the CRC polynomial with 0x1021. cfg_we writes the polynomial and
// must only be used while no frame is pending.
module servo_drive_command_framer_top
  import svf_pkg::*;
#(
  parameter int QUEUE_DEPTH = SVF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  svf_req_if.sink     in_req,
  svf_byte_if.source  out_byte
);

  logic [15:0] poly_r;
  logic        q_full, q_empty, push, pop;
  desc_t       push_desc, head_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= SVF_POLY_RESET;
    end else if (cfg_we) begin
      poly_r <= cfg_wdata;
    end
  end

  svf_front u_front (
    .in_req    (in_req),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  svf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  svf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .poly      (poly_r),
    .head_desc (head_desc),
    .empty     (q_empty),
    .pop       (pop),
    .out_byte  (out_byte)
  );

endmodule

// ===== src/svf_checker.sv =====
module svf_checker
  import svf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  logic [3:0] cnt_r;

  // Byte count within the current frame, as seen on the output port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      cnt_r <= out_last_byte ? '0 : cnt_r + 4'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_last_byte))
    else $error("stalled output item changed");

  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r == 4'd0) |-> out_frame_byte == SVF_SYNC)
    else $error("frame does not start with sync byte");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> (cnt_r == 4'd7) || (cnt_r == 4'd11) ||
      (cnt_r == 4'd13))
    else $error("frame ends at an illegal length");

  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cnt_r == 4'd13) |-> out_last_byte)
    else $error("frame longer than fourteen bytes");

endmodule

bind servo_drive_command_framer_top svf_checker u_svf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_byte.valid),
  .out_ready      (out_byte.ready),
  .out_frame_byte (out_byte.frame_byte),
  .out_last_byte  (out_byte.last_byte)
);

// ===== verif/tb_servo_drive_command_framer_top.sv =====
`timescale 1ns / 1ps

module tb_servo_drive_command_framer_top;
  import svf_pkg::*;

  localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] OP_UNKNOWN_MID = 4'd12;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam int FRAMES_PER_PHASE = 42;
  localparam int NUM_PHASES = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_DIRECTED = 16;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } due_byte_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  addr;
    logic [7:0]  idx;
    logic [31:0] val;
    logic [3:0]  frame_len;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  svf_req_if  req_if ();
  svf_byte_if byte_if ();

  servo_drive_command_framer_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_if),
    .out_byte (byte_if)
  );

  always #1 clk = ~clk;

  due_byte_t  frame_bytes_due[$];
  logic [15:0] crc_poly;
  idle_mode_t idle_mode;
  int         mismatches;
  int         frames_sent;
  int         ignored_reqs;
  int         bytes_checked;
  int         cycle_count;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Augmented MSB-first CRC: message bits shifted in, then two zero bytes.
  function automatic logic [15:0] frame_crc(input logic [7:0] msg [14], input int len,
                                            input logic [15:0] poly);
    logic [15:0] acc;
    logic [7:0]  b;
    logic        top;
    acc = '0;
    for (int i = 0; i < len + 2; i++) begin
      b = (i < len) ? msg[i] : 8'h00;
      for (int k = 7; k >= 0; k--) begin
        top = acc[15];
        acc = {acc[14:0], b[k]};
        if (top) begin
          acc = acc ^ poly;
        end
      end
    end
    return acc;
  endfunction

  // Builds the frame for one request and queues its bytes; returns its length.
  function automatic int queue_frame_bytes(input logic [3:0] op, input logic [7:0] addr,
                                           input logic [7:0] idx, input logic [31:0] val);
    logic [7:0]  fr [14];
    logic [15:0] crc;
    int          paylen;
    int          len;
    due_byte_t   d;
    for (int i = 0; i < 14; i++) begin
      fr[i] = 8'h00;
    end
    paylen = 0;
    fr[0] = SVF_SYNC;
    fr[1] = addr;
    case (op)
      OP_WR_SPEED, OP_WR_CURRENT, OP_WR_POSITION: begin
        fr[2] = CTRL_WR; fr[3] = CODE_WRITE; fr[4] = idx; fr[5] = 8'h02;
        fr[8] = val[7:0]; fr[9] = val[15:8]; fr[10] = val[23:16]; fr[11] = val[31:24];
        paylen = 4;
      end
      OP_RD_CURRENT: begin
        fr[2] = CTRL_RD; fr[3] = CODE_RD_CURRENT; fr[4] = 8'h03; fr[5] = 8'h01;
      end
      OP_RD_SPEED: begin
        fr[2] = CTRL_RD; fr[3] = CODE_RD_SPEED; fr[4] = 8'h02; fr[5] = 8'h02;
      end
      OP_RD_POSITION: begin
        fr[2] = CTRL_RD; fr[3] = CODE_RD_POSITION; fr[4] = 8'h00; fr[5] = 8'h02;
      end
      OP_ACCESS: begin
        fr[2] = CTRL_WR; fr[3] = CODE_ACCESS; fr[4] = 8'h00; fr[5] = 8'h01;
        fr[8] = ACCESS_KEY; paylen = 2;
      end
      OP_ENABLE: begin
        fr[2] = CTRL_WR; fr[3] = CODE_BRIDGE; fr[4] = 8'h00; fr[5] = 8'h01;
        paylen = 2;
      end
      OP_DISABLE: begin
        fr[2] = CTRL_WR; fr[3] = CODE_BRIDGE; fr[4] = 8'h00; fr[5] = 8'h01;
        fr[8] = 8'h01; paylen = 2;
      end
      default: begin
        return 0;
      end
    endcase
    crc = frame_crc(fr, 6, crc_poly);
    fr[6] = crc[15:8];
    fr[7] = crc[7:0];
    len = 8;
    if (paylen > 0) begin
      crc = frame_crc(fr, 8 + paylen, crc_poly);
      fr[8 + paylen] = crc[15:8];
      fr[9 + paylen] = crc[7:0];
      len = 10 + paylen;
    end
    for (int i = 0; i < len; i++) begin
      d.frame_byte = fr[i];
      d.last_byte = (i == len - 1);
      frame_bytes_due.push_back(d);
    end
    return len;
  endfunction

  // Offers one request, with random gaps in front of it when the sender idles,
  // and returns the length of the frame it should produce once it has been taken.
  task automatic send_request(input logic [3:0] op, input logic [7:0] addr,
                              input logic [7:0] idx, input logic [31:0] val,
                              output int len);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 68 : (idle_mode == IDLE_BOTH) ? 16 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.address <= addr;
    req_if.index <= idx;
    req_if.value <= val;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    len = queue_frame_bytes(op, addr, idx, val);
    if (len == 0) begin
      ignored_reqs++;
    end else begin
      frames_sent++;
    end
  endtask

  // Unknown requests leave no trace in the output, so the pipeline gets
  // extra cycles to settle before the polynomial changes.
  task automatic write_poly(input logic [15:0] poly);
    req_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= poly;
    @(posedge clk);
    cfg_we <= 1'b0;
    crc_poly = poly;
  endtask

  initial begin : byte_sink
    due_byte_t d;
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && byte_if.valid && byte_if.ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                    byte_if.frame_byte, byte_if.last_byte));
        end else begin
          d = frame_bytes_due.pop_front();
          bytes_checked++;
          if (byte_if.frame_byte !== d.frame_byte) begin
            report_mismatch($sformatf("frame_byte got %02h want %02h",
                                      byte_if.frame_byte, d.frame_byte));
          end
          if (byte_if.last_byte !== d.last_byte) begin
            report_mismatch($sformatf("last_byte got %0b want %0b",
                                      byte_if.last_byte, d.last_byte));
          end
        end
      end
      case (idle_mode)
        IDLE_RECV: byte_if.ready <= ($urandom_range(0, 99) >= 68);
        IDLE_BOTH: byte_if.ready <= ($urandom_range(0, 99) >= 16);
        default:   byte_if.ready <= 1'b1;
      endcase
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
             frame_bytes_due.size());
    $display("tb_servo_drive_command_framer_top failed");
    $finish;
  end

  initial begin : stimulus
    req_row_t   directed_reqs [NUM_DIRECTED];
    logic [15:0] phase_poly [NUM_PHASES];
    idle_mode_t phase_mode [NUM_PHASES];
    logic [3:0] op;
    logic [31:0] val;
    int         len;
    int         framed;

    // Reads and bridge commands must ignore index and value; unknown
    // operations must produce nothing at all.
    directed_reqs = '{
      '{OP_RD_CURRENT,  8'h00, 8'h00, 32'h0000_0000, 4'd8},
      '{OP_RD_SPEED,    8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'd8},
      '{OP_RD_POSITION, 8'h5A, 8'h33, 32'h1234_5678, 4'd8},
      '{OP_WR_SPEED,    8'h01, 8'h00, 32'h0000_0000, 4'd14},
      '{OP_WR_CURRENT,  8'hFF, 8'hFF, 32'h7FFF_FFFF, 4'd14},
      '{OP_WR_POSITION, 8'h80, 8'h7F, 32'h8000_0000, 4'd14},
      '{OP_WR_SPEED,    8'h7F, 8'h80, 32'hFFFF_FFFF, 4'd14},
      '{OP_ACCESS,      8'h00, 8'hFF, 32'hFFFF_FFFF, 4'd12},
      '{OP_ENABLE,      8'hFF, 8'h55, 32'h5555_AAAA, 4'd12},
      '{OP_DISABLE,     8'h01, 8'hAA, 32'hAAAA_5555, 4'd12},
      '{OP_UNKNOWN_LO,  8'h11, 8'h22, 32'h3333_4444, 4'd0},
      '{OP_UNKNOWN_HI,  8'hFF, 8'hFF, 32'hFFFF_FFFF, 4'd0},
      '{OP_RD_CURRENT,  8'h12, 8'hFF, 32'hFFFF_FFFF, 4'd8},
      '{OP_UNKNOWN_MID, 8'h00, 8'h00, 32'h0000_0000, 4'd0},
      '{OP_WR_POSITION, 8'h00, 8'h01, 32'h0000_0001, 4'd14},
      '{OP_DISABLE,     8'h00, 8'h00, 32'h0000_0000, 4'd12}
    };
    phase_poly = '{16'h0000, 16'hFFFF, 16'h0000, SVF_POLY_RESET, 16'h8005};
    phase_poly[2] = 16'($urandom_range(1, 16'hFFFE));
    phase_mode = '{IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV};

    mismatches = 0;
    frames_sent = 0;
    ignored_reqs = 0;
    bytes_checked = 0;
    crc_poly = SVF_POLY_RESET;
    idle_mode = IDLE_NONE;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.operation <= '0;
    req_if.address <= '0;
    req_if.index <= '0;
    req_if.value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs on the polynomial loaded by reset.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_request(directed_reqs[r].op, directed_reqs[r].addr, directed_reqs[r].idx,
                   directed_reqs[r].val, len);
      if (len != int'(directed_reqs[r].frame_len)) begin
        report_mismatch($sformatf("row %0d frame length %0d, table says %0d", r, len,
                                  directed_reqs[r].frame_len));
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_poly(phase_poly[p]);
      idle_mode = phase_mode[p];
      framed = 0;
      while (framed < FRAMES_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          op = 4'($urandom_range(int'(OP_UNKNOWN_LO), int'(OP_UNKNOWN_HI)));
        end else begin
          op = 4'($urandom_range(int'(OP_WR_SPEED), int'(OP_DISABLE)));
        end
        case ($urandom_range(0, 9))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          3:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), val, len);
        if (len != 0) begin
          framed++;
        end
      end
    end

    req_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d frames (%0d bytes) and %0d ignored requests", frames_sent,
             bytes_checked, ignored_reqs);
    $display("over %0d polynomial settings with mixed sender and receiver idling.",
             NUM_PHASES + 1);
    if (mismatches == 0) begin
      $display("tb_servo_drive_command_framer_top passed");
    end else begin
      $display("tb_servo_drive_command_framer_top failed");
    end
    $finish;
  end

endmodule
